// File: hdl/glyph_column_line_runs_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the glyph column line run block.
// Each macro samples on clk and is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef GLYPH_COLUMN_LINE_RUNS_MACROS_SVH
`define GLYPH_COLUMN_LINE_RUNS_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define GCLR_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("glyph column line runs: check failed");

// Condition c must hold in the cycle after a.
`define GCLR_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("glyph column line runs: check failed");

`endif

// File: hdl/gclr_pkg.sv
// ---------------------------------------------------------------------------
// gclr_pkg
// Shared types, constants and helper functions for the glyph column line
// run block.
// ---------------------------------------------------------------------------
package gclr_pkg;

	localparam int MAX_SCALE  = 8;
	localparam int SCALE_W    = 4;
	localparam int COORD_W    = 8;
	localparam int COMP_W     = 6;
	localparam int BITS_W     = 8;
	localparam int RUN_DEPTH  = 4;
	localparam int RUN_PTR_W  = $clog2(RUN_DEPTH);
	localparam int RUN_CNT_W  = $clog2(RUN_DEPTH + 1);

	// One run of set bits, ready to be expanded into scale line commands.
	typedef struct packed {
		logic [COORD_W-1:0] x_base;
		logic [COORD_W-1:0] row_from;
		logic [COORD_W-1:0] row_to;
		logic [COMP_W-1:0]  red6;
		logic [COMP_W-1:0]  green6;
		logic [COMP_W-1:0]  blue6;
		logic [SCALE_W-1:0] scale_m1;
		logic               last_run;
	} run_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Index of the lowest set bit of a 9-bit word (zero when none).
	function automatic logic [3:0] low_index9(input logic [BITS_W:0] v);
		logic [3:0] idx;
		idx = 4'd0;
		for (int i = BITS_W; i >= 0; i--) begin
			if (v[i]) begin
				idx = 4'(i);
			end
		end
		return idx;
	endfunction

	// Clamp the requested scale to the supported maximum.
	function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] s);
		logic [SCALE_W-1:0] r;
		if (s > SCALE_W'(MAX_SCALE)) begin
			r = SCALE_W'(MAX_SCALE);
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

// File: hdl/gclr_front.sv
// ---------------------------------------------------------------------------
// gclr_front
// Accepts a glyph column item and splits its bitmap into runs of set bits,
// one run per cycle while the queue has room, each as a queued run descriptor.
// ---------------------------------------------------------------------------
module gclr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [gclr_pkg::COORD_W-1:0]        origin_x,
	input  logic [gclr_pkg::COORD_W-1:0]        origin_y,
	input  logic [2:0]                          column_index,
	input  logic [gclr_pkg::BITS_W-1:0]         column_bits,
	input  logic [15:0]                         colour565,
	input  logic [gclr_pkg::SCALE_W-1:0]        scale,
	input  gclr_pkg::queue_status_t             qstat,
	output logic                                push,
	output gclr_pkg::run_t                      push_run
);

	logic                               busy_q;
	logic [gclr_pkg::BITS_W-1:0]        rem_q;
	logic [gclr_pkg::SCALE_W-1:0]       scale_q;
	logic [gclr_pkg::COORD_W-1:0]       oy_q;
	logic [gclr_pkg::COORD_W-1:0]       x_base_q;
	logic [gclr_pkg::COMP_W-1:0]        red_q;
	logic [gclr_pkg::COMP_W-1:0]        green_q;
	logic [gclr_pkg::COMP_W-1:0]        blue_q;

	logic                               accept;
	logic [gclr_pkg::SCALE_W-1:0]       scale_c;
	logic [gclr_pkg::BITS_W-1:0]        low_bit;
	logic [gclr_pkg::BITS_W:0]          sum9;
	logic [gclr_pkg::BITS_W-1:0]        rem_next;
	logic [3:0]                         first_idx;
	logic [3:0]                         past_idx;
	logic [gclr_pkg::COORD_W-1:0]       off_on;
	logic [gclr_pkg::COORD_W-1:0]       off_end;

	assign accept  = start && !busy_q;
	assign scale_c = gclr_pkg::clamp_scale(scale);
	assign busy    = busy_q;

	// Adding the lowest set bit clears the run and carries into the bit past its end (past_idx).
	assign low_bit   = rem_q & (~rem_q + gclr_pkg::BITS_W'(1));
	assign sum9      = {1'b0, rem_q} + {1'b0, low_bit};
	assign rem_next  = rem_q & sum9[gclr_pkg::BITS_W-1:0];
	assign first_idx = gclr_pkg::low_index9({1'b0, rem_q});
	assign past_idx  = gclr_pkg::low_index9(sum9);

	assign off_on  = 8'((8'd7 - {4'b0, first_idx}) * {4'b0, scale_q});
	assign off_end = 8'((8'd7 - {4'b0, past_idx}) * {4'b0, scale_q});

	assign push = busy_q && !qstat.full;

	always_comb begin
		push_run.x_base   = x_base_q;
		push_run.row_from = oy_q + off_on;
		push_run.row_to   = oy_q + off_end + 8'd1;
		push_run.red6     = red_q;
		push_run.green6   = green_q;
		push_run.blue6    = blue_q;
		push_run.scale_m1 = scale_q - gclr_pkg::SCALE_W'(1);
		push_run.last_run = (rem_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			// drop empty columns and zero scale at the door
			busy_q <= (column_bits != '0) && (scale_c != '0);
		end else if (push && (rem_next == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q    <= column_bits;
			scale_q  <= scale_c;
			oy_q     <= origin_y;
			x_base_q <= origin_x + 8'({5'b0, column_index} * {4'b0, scale_c});
			red_q    <= {colour565[15:11], 1'b0};
			green_q  <= colour565[10:5];
			blue_q   <= {colour565[4:0], 1'b0};
		end else if (push) begin
			rem_q <= rem_next;
		end
	end

endmodule

// File: hdl/gclr_queue.sv
// ---------------------------------------------------------------------------
// gclr_queue
// Small FIFO of run descriptors between the scanning front and the line
// emitting back.
// ---------------------------------------------------------------------------
`include "glyph_column_line_runs_macros.svh"

module gclr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  gclr_pkg::run_t          push_run,
	input  logic                    pop,
	output gclr_pkg::run_t          head_run,
	output gclr_pkg::queue_status_t qstat
);

	gclr_pkg::run_t                    mem [gclr_pkg::RUN_DEPTH];
	logic [gclr_pkg::RUN_PTR_W-1:0]    wr_ptr_q;
	logic [gclr_pkg::RUN_PTR_W-1:0]    rd_ptr_q;
	logic [gclr_pkg::RUN_CNT_W-1:0]    count_q;

	assign qstat.full  = (count_q == gclr_pkg::RUN_CNT_W'(gclr_pkg::RUN_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_run    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + gclr_pkg::RUN_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gclr_pkg::RUN_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + gclr_pkg::RUN_CNT_W'(1);
				2'b01:   count_q <= count_q - gclr_pkg::RUN_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`GCLR_ASSERT_IMP(a_no_push_full, push, !qstat.full)
	`GCLR_ASSERT_IMP(a_no_pop_empty, pop, !qstat.empty)
	`GCLR_ASSERT_IMP(a_count_bound, 1'b1, count_q <= gclr_pkg::RUN_CNT_W'(gclr_pkg::RUN_DEPTH))
	`GCLR_ASSERT_NXT(a_push_fills, push && !pop && qstat.empty, !qstat.empty)

endmodule

// File: hdl/gclr_back.sv
// ---------------------------------------------------------------------------
// gclr_back
// Pops run descriptors and emits scale line commands per run, one per cycle
// while runs are queued, on registered result ports.
// ---------------------------------------------------------------------------
module gclr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gclr_pkg::run_t                 head_run,
	input  gclr_pkg::queue_status_t        qstat,
	output logic                           pop,
	output logic                           strobe,
	output logic [gclr_pkg::COORD_W-1:0]   line_x,
	output logic [gclr_pkg::COORD_W-1:0]   row_from,
	output logic [gclr_pkg::COORD_W-1:0]   row_to,
	output logic [gclr_pkg::COMP_W-1:0]    red6,
	output logic [gclr_pkg::COMP_W-1:0]    green6,
	output logic [gclr_pkg::COMP_W-1:0]    blue6,
	output logic                           last_line
);

	gclr_pkg::run_t                  cur_q;
	logic                            cur_valid_q;
	logic [gclr_pkg::SCALE_W-1:0]    cnt_q;
	logic                            strobe_q;
	logic [gclr_pkg::COORD_W-1:0]    line_x_q;
	logic [gclr_pkg::COORD_W-1:0]    row_from_q;
	logic [gclr_pkg::COORD_W-1:0]    row_to_q;
	logic [gclr_pkg::COMP_W-1:0]     red_q;
	logic [gclr_pkg::COMP_W-1:0]     green_q;
	logic [gclr_pkg::COMP_W-1:0]     blue_q;
	logic                            last_q;

	logic                            run_done;

	assign run_done = cur_valid_q && (cnt_q == cur_q.scale_m1);
	assign pop      = (!cur_valid_q || run_done) && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cnt_q       <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= cur_valid_q;
			if (pop) begin
				cur_valid_q <= 1'b1;
				cnt_q       <= '0;
			end else if (run_done) begin
				cur_valid_q <= 1'b0;
				cnt_q       <= '0;
			end else if (cur_valid_q) begin
				cnt_q <= cnt_q + gclr_pkg::SCALE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_run;
		end
		if (cur_valid_q) begin
			line_x_q   <= cur_q.x_base + {4'b0, cnt_q};
			row_from_q <= cur_q.row_from;
			row_to_q   <= cur_q.row_to;
			red_q      <= cur_q.red6;
			green_q    <= cur_q.green6;
			blue_q     <= cur_q.blue6;
			last_q     <= run_done && cur_q.last_run;
		end
	end

	assign strobe    = strobe_q;
	assign line_x    = line_x_q;
	assign row_from  = row_from_q;
	assign row_to    = row_to_q;
	assign red6      = red_q;
	assign green6    = green_q;
	assign blue6     = blue_q;
	assign last_line = last_q;

endmodule

// File: hdl/glyph_column_line_runs.sv
// ---------------------------------------------------------------------------
// glyph_column_line_runs
// Turns one glyph column bitmap into vertical draw-line commands, scale
// lines per run of set bits.
// ---------------------------------------------------------------------------
// channel   handshake              payload
// item      start & !busy          origin_x origin_y column_index column_bits
//                                  colour565 scale
// line      strobe (one cycle)     line_x row_from row_to red6 green6 blue6
//                                  last_line
//
// The front scans one run per cycle while the run queue has room, and holds busy
// until the last run of an item (up to four) is pushed; a full queue stalls the scan.
// The four-entry run queue lets the front run ahead of the back.
// The back emits one line per cycle while runs are queued: a column gives
// runs * scale lines, at most 32, and the line unit sets the sustained rate.
// A queued run passes the back's current-run register, then the output registers.
// Reset clears the control state; the receiver cannot stall.
// ---------------------------------------------------------------------------
module glyph_column_line_runs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [gclr_pkg::COORD_W-1:0]  origin_x,
	input  logic [gclr_pkg::COORD_W-1:0]  origin_y,
	input  logic [2:0]                    column_index,
	input  logic [gclr_pkg::BITS_W-1:0]   column_bits,
	input  logic [15:0]                   colour565,
	input  logic [gclr_pkg::SCALE_W-1:0]  scale,
	output logic                          strobe,
	output logic [gclr_pkg::COORD_W-1:0]  line_x,
	output logic [gclr_pkg::COORD_W-1:0]  row_from,
	output logic [gclr_pkg::COORD_W-1:0]  row_to,
	output logic [gclr_pkg::COMP_W-1:0]   red6,
	output logic [gclr_pkg::COMP_W-1:0]   green6,
	output logic [gclr_pkg::COMP_W-1:0]   blue6,
	output logic                          last_line
);

	gclr_pkg::queue_status_t qstat;
	gclr_pkg::run_t          push_run;
	gclr_pkg::run_t          head_run;
	logic                    push;
	logic                    pop;

	gclr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.column_index (column_index),
		.column_bits  (column_bits),
		.colour565    (colour565),
		.scale        (scale),
		.qstat        (qstat),
		.push         (push),
		.push_run     (push_run)
	);

	gclr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.head_run (head_run),
		.qstat    (qstat)
	);

	gclr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_run  (head_run),
		.qstat     (qstat),
		.pop       (pop),
		.strobe    (strobe),
		.line_x    (line_x),
		.row_from  (row_from),
		.row_to    (row_to),
		.red6      (red6),
		.green6    (green6),
		.blue6     (blue6),
		.last_line (last_line)
	);

endmodule
